// File: design/frq_pkg.sv
// ----------------------------------------------------------------------------
// frq_pkg: shared types and constants of the run queue
// Transaction structs, mode codes, per-cell control group and defaults.
// ----------------------------------------------------------------------------
package frq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int TASK_BITS_DEF = 16;

   localparam int MODE_W  = 2;
   localparam int TASK_W  = 16;
   localparam int COUNT_W = 5;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TASK_W-1:0] task_id;
   } frq_req_type;

   typedef struct packed {
      logic               ok;
      logic [TASK_W-1:0]  taken_task;
      logic [TASK_W-1:0]  front_task;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
      logic               full_res;
   } frq_rsp_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic clear;
      logic dequeue;
      logic remove;
      logic enqueue;
   } frq_ctl_type;

endpackage

// File: design/frq_cell.sv
// ----------------------------------------------------------------------------
// frq_cell: one queue slot
// Holds one task, compares it against the broadcast task, passes a found
// flag toward the back and takes its back neighbor's task when compacting.
// ----------------------------------------------------------------------------
module frq_cell #(
   parameter int TASK_BITS = 16,
   parameter int CNT_W     = 5,
   parameter int POS       = 0
) (
   input  logic                   clock,
   input  frq_pkg::frq_ctl_type   ctl,
   input  logic [TASK_BITS-1:0]   task_in,
   input  logic [CNT_W-1:0]       count_in,
   input  logic [TASK_BITS-1:0]   next_entry,
   input  logic                   found_in,
   output logic [TASK_BITS-1:0]   entry,
   output logic                   found_out
);
   import frq_pkg::*;

   logic [TASK_BITS-1:0] entry_ff;
   logic [TASK_BITS-1:0] entry_in;
   logic                 at_back;

   assign at_back   = (count_in == CNT_W'(POS));
   assign found_out = found_in | (entry_ff == task_in);
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.clear) begin
         entry_in = '0;
      end else if (ctl.dequeue) begin
         entry_in = next_entry;
      end else if (ctl.remove && found_out) begin
         // this slot and everything behind the match moves up one
         entry_in = next_entry;
      end else if (ctl.enqueue && at_back) begin
         entry_in = task_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/fifo_run_queue_with_removal_top.sv
// ----------------------------------------------------------------------------
// fifo_run_queue_with_removal_top: FIFO run queue with removal by task id
// Row of slot cells, front at slot 0, with count and capacity control.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   req_data carries the mode (enqueue, dequeue, remove) and the task id.
//   busy stays low: every slot cell compares, shifts and loads in the same
//   cycle, so one transaction is taken per clock.
//   The result appears on rsp_data with rsp_valid high for exactly one cycle,
//   the cycle after the transaction is taken. The receiver cannot stall;
//   results are never held.
//   The search for a remove runs as a found flag passed from cell to cell,
//   front to back, in the same cycle as the transaction is taken.
//   csr_data sets the capacity (0 taken as 1, above DEPTH taken as DEPTH);
//   csr_ready is always high and a write empties the queue. Write it only
//   while no transaction is in flight.
//   Synchronous reset empties the queue and sets capacity to DEPTH.
// ----------------------------------------------------------------------------
module fifo_run_queue_with_removal_top #(
   parameter int DEPTH     = frq_pkg::DEPTH_DEF,
   parameter int TASK_BITS = frq_pkg::TASK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  frq_pkg::frq_req_type req_data,
   output logic                 rsp_valid,
   output frq_pkg::frq_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [frq_pkg::COUNT_W-1:0] csr_data
);
   import frq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [TASK_BITS-1:0] entries [DEPTH];
   logic [DEPTH:0]       found_chain;
   logic [TASK_BITS-1:0] task_w;
   logic [31:0]          task_ext;
   logic [31:0]          front_ext;
   logic [31:0]          taken_ext;
   logic [31:0]          count_ext;
   logic [31:0]          cap_ext;
   frq_ctl_type          ctl;

   logic                 accept;
   logic                 task_nz;
   logic                 enq_ok;
   logic                 deq_ok;
   logic                 rm_ok;
   logic                 csr_write;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ok_ff, ok_in;
   logic [TASK_BITS-1:0] taken_ff, taken_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;

   assign task_ext = {16'b0, req_data.task_id};
   assign task_w   = task_ext[TASK_BITS-1:0];
   assign task_nz  = (task_w != '0);

   assign enq_ok = accept && (req_data.mode == MODE_ENQUEUE) && task_nz
                   && (count_ff < cap_ff);
   assign deq_ok = accept && (req_data.mode == MODE_DEQUEUE) && (count_ff != '0);
   // empty slots hold zero, so a nonzero task never matches past the back
   assign rm_ok  = accept && (req_data.mode == MODE_REMOVE) && task_nz
                   && found_chain[DEPTH];

   always_comb begin
      ctl.clear   = reset | csr_write;
      ctl.dequeue = deq_ok;
      ctl.remove  = rm_ok;
      ctl.enqueue = enq_ok;
   end

   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [TASK_BITS-1:0] next_w;
      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid
         assign next_w = entries[i+1];
      end
      frq_cell #(
         .TASK_BITS (TASK_BITS),
         .CNT_W     (CNT_W),
         .POS       (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .task_in    (task_w),
         .count_in   (count_ff),
         .next_entry (next_w),
         .found_in   (found_chain[i]),
         .entry      (entries[i]),
         .found_out  (found_chain[i+1])
      );
   end

   // capacity clamp to 1..DEPTH
   always_comb begin
      cap_ext = {27'b0, csr_data};
      if (cap_ext == 32'd0) begin
         cap_ext = 32'd1;
      end else if (cap_ext > 32'(DEPTH)) begin
         cap_ext = 32'(DEPTH);
      end
      cap_in = cap_ff;
      if (csr_write) begin
         cap_in = cap_ext[CNT_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (csr_write) begin
         count_in = '0;
      end else if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok || rm_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_valid_in = accept;
      ok_in        = enq_ok | deq_ok | rm_ok;
      taken_in     = deq_ok ? entries[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
      end
      taken_ff <= taken_in;
   end

   // status reflects the state left by the transaction just completed
   assign front_ext = 32'(entries[0]);
   assign taken_ext = 32'(taken_ff);
   assign count_ext = 32'(count_ff);

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.ok         = ok_ff;
      rsp_data.taken_task = taken_ext[TASK_W-1:0];
      rsp_data.front_task = front_ext[TASK_W-1:0];
      rsp_data.count      = count_ext[COUNT_W-1:0];
      rsp_data.empty_res  = (count_ff == '0);
      rsp_data.full_res   = (count_ff >= cap_ff);
   end

endmodule
